FILE: src/ntc_pkg.sv
package ntc_pkg;

    // Defaults for the top-level parameters
    localparam int DEF_IMAGE_SIDE    = 16;
    localparam int DEF_NUM_TEMPLATES = 64;

    // Fixed field widths
    localparam int OP_W    = 2;
    localparam int TIDX_W  = 6;
    localparam int POS_W   = 8;
    localparam int PIXEL_W = 8;
    localparam int LABEL_W = 4;
    localparam int DIST_W  = 16;

    localparam int S_TDATA_W = 32;  // 26 bits of fields, padded to whole bytes
    localparam int M_TDATA_W = 24;  // 20 bits of fields, padded to whole bytes

    localparam logic [DIST_W-1:0] DIST_MAX = '1;

    // Request kinds carried on s_tuser
    localparam logic [OP_W-1:0] OP_PIXEL_WR = 2'd0;
    localparam logic [OP_W-1:0] OP_LABEL_WR = 2'd1;
    localparam logic [OP_W-1:0] OP_TEST     = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SWEEP,
        ST_DRAIN,
        ST_LABEL,
        ST_RESULT
    } ctrl_state_t;

    typedef struct packed {
        logic accept;      // input request taken this cycle
        logic issue;       // read one template's pixel and sum
        logic sweep_end;   // last template processed this cycle
        logic label_read;  // fetch label of the winner
        logic out_load;    // move the result into the output register
    } ctrl_cmd_t;

    typedef struct packed {
        logic in_is_test;  // request at the input is a test pixel
        logic issue_last;  // sweep counter sits on the final template
        logic last_item;   // latched test pixel closes the image
        logic out_free;    // output register can take a result
    } dp_status_t;

endpackage

FILE: src/ntc_ctrl.sv
module ntc_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  ntc_pkg::dp_status_t status,
    output ntc_pkg::ctrl_cmd_t  cmd
);

    ntc_pkg::ctrl_state_t state_reg;
    ntc_pkg::ctrl_state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ntc_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        s_tready   = 1'b0;
        cmd        = '0;
        unique case (state_reg)
            ntc_pkg::ST_IDLE: begin
                s_tready   = 1'b1;
                cmd.accept = s_tvalid;
                if (s_tvalid && status.in_is_test) begin
                    state_next = ntc_pkg::ST_SWEEP;
                end
            end
            ntc_pkg::ST_SWEEP: begin
                cmd.issue = 1'b1;
                if (status.issue_last) begin
                    state_next = ntc_pkg::ST_DRAIN;
                end
            end
            ntc_pkg::ST_DRAIN: begin
                cmd.sweep_end = 1'b1;
                state_next    = status.last_item ? ntc_pkg::ST_LABEL : ntc_pkg::ST_IDLE;
            end
            ntc_pkg::ST_LABEL: begin
                cmd.label_read = 1'b1;
                state_next     = ntc_pkg::ST_RESULT;
            end
            ntc_pkg::ST_RESULT: begin
                if (status.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ntc_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = ntc_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

FILE: src/ntc_datapath.sv
module ntc_datapath #(
    parameter int IMAGE_SIDE    = ntc_pkg::DEF_IMAGE_SIDE,
    parameter int NUM_TEMPLATES = ntc_pkg::DEF_NUM_TEMPLATES
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  ntc_pkg::ctrl_cmd_t            cmd,
    output ntc_pkg::dp_status_t           status,
    input  logic [ntc_pkg::OP_W-1:0]      operation,
    input  logic [ntc_pkg::TIDX_W-1:0]    template_index,
    input  logic [ntc_pkg::POS_W-1:0]     pixel_index,
    input  logic [ntc_pkg::PIXEL_W-1:0]   pixel_value,
    input  logic [ntc_pkg::LABEL_W-1:0]   class_label,
    input  logic                          last_pixel,
    input  logic                          m_tready,
    output logic                          m_tvalid,
    output logic [ntc_pkg::LABEL_W-1:0]   best_label,
    output logic [ntc_pkg::DIST_W-1:0]    min_distance
);

    localparam int PIX   = IMAGE_SIDE * IMAGE_SIDE;
    localparam int DEPTH = NUM_TEMPLATES * PIX;
    localparam int TW    = (NUM_TEMPLATES > 1) ? $clog2(NUM_TEMPLATES) : 1;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    // Stores
    logic [ntc_pkg::PIXEL_W-1:0] pix_mem [DEPTH];
    logic [ntc_pkg::LABEL_W-1:0] lbl_mem [NUM_TEMPLATES];
    logic [ntc_pkg::DIST_W-1:0]  sum_mem [NUM_TEMPLATES];

    // Decode of the incoming request
    logic          tidx_ok;
    logic          pos_ok;
    logic [AW-1:0] wr_addr;
    logic [TW-1:0] wr_tidx;

    assign tidx_ok = ({26'd0, template_index} < NUM_TEMPLATES);
    assign pos_ok  = ({24'd0, pixel_index} < PIX);
    assign wr_addr = AW'(32'(template_index) * 32'(PIX) + 32'(pixel_index));
    assign wr_tidx = TW'(template_index);

    // Latched test pixel and sweep state
    logic [ntc_pkg::PIXEL_W-1:0] value_reg, value_next;
    logic                        pos_ok_reg, pos_ok_next;
    logic                        last_reg, last_next;
    logic [AW-1:0]               addr_reg, addr_next;
    logic [TW-1:0]               issue_idx_reg, issue_idx_next;
    logic                        first_reg, first_next;

    // Read stage
    logic                        proc_valid_reg;
    logic [TW-1:0]               proc_idx_reg;
    logic [ntc_pkg::PIXEL_W-1:0] pix_q;
    logic [ntc_pkg::DIST_W-1:0]  sum_q;

    // Running minimum
    logic [ntc_pkg::DIST_W-1:0]  best_sum_reg, best_sum_next;
    logic [TW-1:0]               best_idx_reg, best_idx_next;
    logic [ntc_pkg::LABEL_W-1:0] label_q;

    // Output register
    logic                        out_valid_reg, out_valid_next;
    logic [ntc_pkg::LABEL_W-1:0] out_label_reg;
    logic [ntc_pkg::DIST_W-1:0]  out_dist_reg;

    // Accumulate step
    logic [ntc_pkg::DIST_W-1:0]  old_sum;
    logic [ntc_pkg::PIXEL_W-1:0] diff;
    logic [ntc_pkg::DIST_W:0]    wide_sum;
    logic [ntc_pkg::DIST_W-1:0]  new_sum;

    always_comb begin
        old_sum  = first_reg ? '0 : sum_q;
        if (!pos_ok_reg) begin
            diff = '0;
        end else if (value_reg > pix_q) begin
            diff = value_reg - pix_q;
        end else begin
            diff = pix_q - value_reg;
        end
        wide_sum = {1'b0, old_sum} + {9'd0, diff};
        new_sum  = wide_sum[ntc_pkg::DIST_W] ? ntc_pkg::DIST_MAX
                                               : wide_sum[ntc_pkg::DIST_W-1:0];
    end

    always_comb begin
        value_next     = value_reg;
        pos_ok_next    = pos_ok_reg;
        last_next      = last_reg;
        addr_next      = addr_reg;
        issue_idx_next = issue_idx_reg;
        first_next     = first_reg;
        best_sum_next  = best_sum_reg;
        best_idx_next  = best_idx_reg;
        out_valid_next = out_valid_reg;

        if (cmd.accept && (operation == ntc_pkg::OP_TEST)) begin
            value_next     = pixel_value;
            pos_ok_next    = pos_ok;
            last_next      = last_pixel;
            addr_next      = pos_ok ? AW'(pixel_index) : '0;
            issue_idx_next = '0;
        end else if (cmd.issue) begin
            addr_next      = addr_reg + AW'(PIX);
            issue_idx_next = issue_idx_reg + TW'(1);
        end

        // Sums count as zero until the first sweep of an image writes them
        if (cmd.sweep_end) begin
            first_next = last_reg;
        end

        if (proc_valid_reg && ((proc_idx_reg == '0) || (new_sum < best_sum_reg))) begin
            best_sum_next = new_sum;
            best_idx_next = proc_idx_reg;
        end

        if (cmd.out_load) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            issue_idx_reg  <= '0;
            first_reg      <= 1'b1;
            proc_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            last_reg       <= 1'b0;
        end else begin
            issue_idx_reg  <= issue_idx_next;
            first_reg      <= first_next;
            proc_valid_reg <= cmd.issue;
            out_valid_reg  <= out_valid_next;
            last_reg       <= last_next;
        end
    end

    always_ff @(posedge aclk) begin
        value_reg    <= value_next;
        pos_ok_reg   <= pos_ok_next;
        addr_reg     <= addr_next;
        proc_idx_reg <= issue_idx_reg;
        best_sum_reg <= best_sum_next;
        best_idx_reg <= best_idx_next;
        if (cmd.out_load) begin
            out_label_reg <= label_q;
            out_dist_reg  <= best_sum_reg;
        end
    end

    // Template pixel store
    always_ff @(posedge aclk) begin
        if (cmd.accept && (operation == ntc_pkg::OP_PIXEL_WR) && tidx_ok && pos_ok) begin
            pix_mem[wr_addr] <= pixel_value;
        end
        if (cmd.issue) begin
            pix_q <= pix_mem[addr_reg];
        end
    end

    // Label store
    always_ff @(posedge aclk) begin
        if (cmd.accept && (operation == ntc_pkg::OP_LABEL_WR) && tidx_ok) begin
            lbl_mem[wr_tidx] <= class_label;
        end
        if (cmd.label_read) begin
            label_q <= lbl_mem[best_idx_reg];
        end
    end

    // Distance sum store
    always_ff @(posedge aclk) begin
        if (proc_valid_reg) begin
            sum_mem[proc_idx_reg] <= new_sum;
        end
        if (cmd.issue) begin
            sum_q <= sum_mem[issue_idx_reg];
        end
    end

    assign status.in_is_test = (operation == ntc_pkg::OP_TEST);
    assign status.issue_last = (issue_idx_reg == TW'(NUM_TEMPLATES - 1));
    assign status.last_item  = last_reg;
    assign status.out_free   = !out_valid_reg || m_tready;

    assign m_tvalid     = out_valid_reg;
    assign best_label   = out_label_reg;
    assign min_distance = out_dist_reg;

    a_load_only_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> (!out_valid_reg || m_tready))
        else $error("result loaded over an unaccepted result");

    a_load_shows_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |=> out_valid_reg)
        else $error("loaded result not presented");

    a_read_follows_issue: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.issue |=> (proc_valid_reg && (proc_idx_reg == $past(issue_idx_reg))))
        else $error("read stage lost track of the issued template");

    a_best_not_above: assert property (@(posedge aclk) disable iff (!aresetn)
        (proc_valid_reg && (proc_idx_reg != '0)) |=> (best_sum_reg <= $past(new_sum)))
        else $error("running minimum exceeds a processed sum");

endmodule

FILE: src/nearest_template_l1_classifier_top.sv
// Nearest-template classifier, L1 distance, one template per cycle.
//
// Input channel (s_*): one request per handshake. s_tuser carries the kind:
// write template pixel, write template label, or test pixel. s_tlast marks the
// final test pixel of an image and is ignored on writes. Load templates and
// labels first, then stream a test image pixel by pixel.
// Result channel (m_*): one result per test image, label and L1 distance of
// the closest template; ties go to the lowest template index.
//
// Sequence: a write request is taken in the idle state. A test pixel starts a
// sweep that reads one template pixel and one running sum per cycle from
// single-port-read memories and writes the updated sum back in the cycle after;
// s_tready stays low until the sweep has drained. The final pixel adds a label
// lookup, and its result then shows on m_tvalid from the output register.
// Reset: aresetn (synchronous, active low) returns to idle and marks all
// running sums as zero; template stores are not cleared.
// Stall: a result waits in the output register while m_tready is low; further
// requests are taken meanwhile; the next result waits for the slot with s_tready low.
module nearest_template_l1_classifier_top #(
    parameter int IMAGE_SIDE    = ntc_pkg::DEF_IMAGE_SIDE,
    parameter int NUM_TEMPLATES = ntc_pkg::DEF_NUM_TEMPLATES
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // template_index[5:0], pixel_index[13:6], pixel_value[21:14],
    // class_label[25:22], zero[31:26]
    input  logic [ntc_pkg::S_TDATA_W-1:0]   s_tdata,
    // operation[1:0]
    input  logic [ntc_pkg::OP_W-1:0]        s_tuser,
    input  logic                            s_tlast,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // match_label[3:0], min_distance[19:4], zero[23:20]
    output logic [ntc_pkg::M_TDATA_W-1:0]   m_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready
);

    ntc_pkg::ctrl_cmd_t  cmd;
    ntc_pkg::dp_status_t status;

    logic [ntc_pkg::LABEL_W-1:0] best_label;
    logic [ntc_pkg::DIST_W-1:0]  min_distance;

    // Sequencer: idle / sweep over templates / drain / label fetch / result
    ntc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // Stores, accumulate-and-compare stage, output register
    ntc_datapath #(
        .IMAGE_SIDE    (IMAGE_SIDE),
        .NUM_TEMPLATES (NUM_TEMPLATES)
    ) u_datapath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .status         (status),
        .operation      (s_tuser),
        .template_index (s_tdata[5:0]),
        .pixel_index    (s_tdata[13:6]),
        .pixel_value    (s_tdata[21:14]),
        .class_label    (s_tdata[25:22]),
        .last_pixel     (s_tlast),
        .m_tready       (m_tready),
        .m_tvalid       (m_tvalid),
        .best_label     (best_label),
        .min_distance   (min_distance)
    );

    assign m_tdata = {4'd0, min_distance, best_label};

endmodule
